// ----- rtl/wplm_pkg.sv -----
// Shared types and constants for the windowed peak level meter.
// Used by wplm_ctrl, wplm_dp and windowed_peak_level_meter_core.
package wplm_pkg;

	// Ring of recent block peaks
	localparam int WINDOW_BLOCKS = 16;
	localparam int RING_AW       = (WINDOW_BLOCKS > 1) ? $clog2(WINDOW_BLOCKS) : 1;

	// Field widths
	localparam int SAMPLE_W = 24;
	localparam int PEAK_W   = 23;
	localparam int LEVEL_W  = 17;

	// Log unit: mantissa in Q1.31, 24 fractional bits of log2
	localparam int MANT_W      = 32;
	localparam int FRAC_BITS   = 24;
	localparam int FRAC_CNT_W  = $clog2(FRAC_BITS);
	localparam int SHIFT_W     = $clog2(PEAK_W + 1);
	localparam int MAG_W       = SHIFT_W + FRAC_BITS;
	localparam int K_W         = 31;
	localparam int PROD_W      = MAG_W + K_W;
	localparam int RND_SHIFT   = 44;
	localparam int Q_W         = LEVEL_W - 1;

	// 20*log10(2)*256 in Q20
	localparam logic [K_W-1:0]     LVL_K     = K_W'(1616142483);
	// -144 dB in 1/256 dB
	localparam logic [LEVEL_W-1:0] LVL_FLOOR = LEVEL_W'(-36864);

	// Controller to datapath commands
	typedef struct packed {
		logic take;      // input transaction accepted
		logic scan;      // read ring entry, fold previous one into max
		logic load;      // fold last entry, load normaliser
		logic norm;      // one normalising shift
		logic sqr;       // one squaring step of the log
		logic mul;       // scale by LVL_K
		logic rnd;       // round and negate
		logic out_load;  // load output register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic scan_last;
		logic peak_zero;
		logic norm_done;
		logic sq_last;
	} stat_t;

endpackage

// ----- rtl/windowed_peak_level_meter_core.sv -----
// Top level of the windowed peak level meter: controller plus datapath.
// Depends on wplm_pkg, wplm_ctrl and wplm_dp.
//
//   channel  direction  handshake           payload
//   in       to core    in_valid/in_stall   sample, last_in_block
//   out      from core  out_valid/out_stall level_db, window_peak
//
// A sample that is not last in its block is taken without a stall. A last
// sample is followed by a walk over the 16 entries of the peak ring through its
// single read port, up to 22 normalising shifts, 24 squarings on the 32x32
// multiplier of the log unit, then scaling, rounding and output load; a
// silent window skips the log unit. Reset clears the block peak, write
// index and ring valid bits at once. in_stall is high while a block end
// is being worked; a result waiting in the output register holds the
// core only when the next result is ready.
module windowed_peak_level_meter_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [wplm_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 last_in_block,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [wplm_pkg::LEVEL_W-1:0]  level_db,
	output logic        [wplm_pkg::PEAK_W-1:0]   window_peak
);
	import wplm_pkg::*;

	cmd_t  cmd;
	stat_t st;

	wplm_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.last_in_block (last_in_block),
		.in_stall      (in_stall),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.cmd           (cmd),
		.st            (st)
	);

	wplm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample        (sample),
		.last_in_block (last_in_block),
		.cmd           (cmd),
		.st            (st),
		.level_db      (level_db),
		.window_peak   (window_peak)
	);

endmodule

// ----- rtl/wplm_ctrl.sv -----
// Controller state machine for the windowed peak level meter.
// Depends on wplm_pkg; drives commands into wplm_dp.
module wplm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           last_in_block,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	output wplm_pkg::cmd_t cmd,
	input  wplm_pkg::stat_t st
);
	import wplm_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_LOAD = 3'd2;
	localparam logic [2:0] S_NORM = 3'd3;
	localparam logic [2:0] S_SQR  = 3'd4;
	localparam logic [2:0] S_MUL  = 3'd5;
	localparam logic [2:0] S_RND  = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					if (last_in_block) state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_last) state_d = S_LOAD;
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_NORM;
			end
			S_NORM: begin
				priority if (st.peak_zero) begin
					state_d = S_OUT;
				end else if (st.norm_done) begin
					state_d = S_SQR;
				end else begin
					cmd.norm = 1'b1;
				end
			end
			S_SQR: begin
				cmd.sqr = 1'b1;
				if (st.sq_last) state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_RND;
			end
			S_RND: begin
				cmd.rnd = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				// wait for the output register to free up
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- rtl/wplm_dp.sv -----
// Datapath for the windowed peak level meter: block peak, peak ring,
// window maximum scan, log2 unit and dB scaling. Depends on wplm_pkg.
module wplm_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic signed [wplm_pkg::SAMPLE_W-1:0] sample,
	input  logic                               last_in_block,
	input  wplm_pkg::cmd_t                     cmd,
	output wplm_pkg::stat_t                    st,
	output logic signed [wplm_pkg::LEVEL_W-1:0]  level_db,
	output logic        [wplm_pkg::PEAK_W-1:0]   window_peak
);
	import wplm_pkg::*;

	localparam logic [RING_AW-1:0]    RING_LAST = RING_AW'(WINDOW_BLOCKS - 1);
	localparam logic [FRAC_CNT_W-1:0] SQ_LAST   = FRAC_CNT_W'(FRAC_BITS - 1);
	localparam logic [PROD_W:0]       RND_HALF  = (PROD_W + 1)'(1) << (RND_SHIFT - 1);
	localparam int                    PAD_W     = MANT_W - PEAK_W;

	// Block peak and ring state
	logic [PEAK_W-1:0]        run_q;
	logic [RING_AW-1:0]       widx_q;
	logic [WINDOW_BLOCKS-1:0] vld_q;
	logic [PEAK_W-1:0]        mem [WINDOW_BLOCKS];

	// Scan
	logic [RING_AW-1:0]       scan_cnt_q;
	logic [PEAK_W-1:0]        rd_data_q;
	logic                     rd_vld_q;
	logic [PEAK_W-1:0]        wmax_q;

	// Log unit
	logic [MANT_W-1:0]        x_q;
	logic [SHIFT_W-1:0]       sh_q;
	logic [FRAC_BITS-1:0]     f_q;
	logic [FRAC_CNT_W-1:0]    sq_cnt_q;
	logic [PROD_W-1:0]        prod_q;
	logic [LEVEL_W-1:0]       lvl_q;

	// Output register
	logic [LEVEL_W-1:0]       level_q;
	logic [PEAK_W-1:0]        wpeak_q;

	logic [SAMPLE_W-1:0]      neg;
	logic [PEAK_W-1:0]        mag;
	logic [PEAK_W-1:0]        blk_pk;
	logic [PEAK_W-1:0]        rd_val;
	logic [PEAK_W-1:0]        fold_max;
	logic [2*MANT_W-1:0]      sq;
	logic [MAG_W-1:0]         log_mag;
	logic [PROD_W:0]          rsum;
	logic [Q_W-1:0]           q;

	// Sample magnitude, most negative value saturates
	always_comb begin
		neg = (~sample) + SAMPLE_W'(1);
		if (sample[SAMPLE_W-1]) begin
			mag = neg[SAMPLE_W-1] ? {PEAK_W{1'b1}} : neg[PEAK_W-1:0];
		end else begin
			mag = sample[PEAK_W-1:0];
		end
		blk_pk = (mag > run_q) ? mag : run_q;
	end

	// Ring entry that was never written reads as zero
	assign rd_val   = rd_vld_q ? rd_data_q : '0;
	assign fold_max = (rd_val > wmax_q) ? rd_val : wmax_q;

	// Squaring step and dB scaling terms
	assign sq      = x_q * x_q;
	assign log_mag = {sh_q + SHIFT_W'(1), {FRAC_BITS{1'b0}}} - MAG_W'(f_q);
	assign rsum    = {1'b0, prod_q} + RND_HALF;
	assign q       = rsum[RND_SHIFT +: Q_W];

	// Control state: block peak, write index, valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= '0;
			widx_q <= '0;
			vld_q  <= '0;
		end else if (cmd.take) begin
			if (last_in_block) begin
				run_q          <= '0;
				vld_q[widx_q]  <= 1'b1;
				widx_q         <= (widx_q == RING_LAST) ? '0 : widx_q + RING_AW'(1);
			end else begin
				run_q <= blk_pk;
			end
		end
	end

	// Peak ring memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.take && last_in_block) mem[widx_q] <= blk_pk;
		rd_data_q <= mem[scan_cnt_q];
		rd_vld_q  <= vld_q[scan_cnt_q];
	end

	// Window scan and log unit
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			scan_cnt_q <= '0;
			wmax_q     <= '0;
		end
		if (cmd.scan) begin
			scan_cnt_q <= scan_cnt_q + RING_AW'(1);
			if (scan_cnt_q != '0) wmax_q <= fold_max;
		end
		if (cmd.load) begin
			wmax_q   <= fold_max;
			x_q      <= {fold_max, {PAD_W{1'b0}}};
			sh_q     <= '0;
			f_q      <= '0;
			sq_cnt_q <= '0;
		end
		if (cmd.norm) begin
			x_q  <= {x_q[MANT_W-2:0], 1'b0};
			sh_q <= sh_q + SHIFT_W'(1);
		end
		// One fractional bit of log2 per square
		if (cmd.sqr) begin
			sq_cnt_q <= sq_cnt_q + FRAC_CNT_W'(1);
			if (sq[2*MANT_W-1]) begin
				x_q <= sq[2*MANT_W-1 -: MANT_W];
				f_q <= {f_q[FRAC_BITS-2:0], 1'b1};
			end else begin
				x_q <= sq[2*MANT_W-2 -: MANT_W];
				f_q <= {f_q[FRAC_BITS-2:0], 1'b0};
			end
		end
		if (cmd.mul) prod_q <= PROD_W'(log_mag) * PROD_W'(LVL_K);
		if (cmd.rnd) lvl_q  <= LEVEL_W'(0) - {1'b0, q};
		if (cmd.out_load) begin
			level_q <= (wmax_q == '0) ? LVL_FLOOR : lvl_q;
			wpeak_q <= wmax_q;
		end
	end

	assign st.scan_last = (scan_cnt_q == RING_LAST);
	assign st.peak_zero = (x_q == '0);
	assign st.norm_done = x_q[MANT_W-1];
	assign st.sq_last   = (sq_cnt_q == SQ_LAST);

	assign level_db    = signed'(level_q);
	assign window_peak = wpeak_q;

endmodule
